@@ hw/rtl/ifr_pkg.sv @@
// shared types, constants and register codes of the information frame receiver
package ifr_pkg;

   localparam int MAX_RAW_BYTES = 1024;
   localparam int RAW_W = $clog2(MAX_RAW_BYTES);
   localparam int LEN_W = 11;
   localparam int HEADER_BYTES = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_ZERO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_ONE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK = 3'd5;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [7:0]       payload_byte;
      logic             frame_good;
      logic             sequence_number;
      logic [LEN_W-1:0] payload_length;
      logic [LEN_W-1:0] received_bytes;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic       clear;
      logic       eq_flag;
      logic       eq_addr;
      logic       eq_ctrl_zero;
      logic       eq_ctrl_one;
      logic       eq_hdr_zero;
      logic       eq_hdr_one;
      logic       eq_escape;
      logic [7:0] rx_byte;
   } cls_type;

   typedef struct packed {
      logic push;
   } qin_type;

   typedef struct packed {
      logic pop;
   } qout_type;

endpackage

@@ hw/rtl/info_frame_receiver.sv @@
// top level of the information frame receiver: front, queue and back
//
//   channel   direction   handshake           payload
//   req       in          req_valid/stall     req_item (operation, rx_byte)
//   rsp       out         rsp_valid/stall     rsp_item (result fields)
//   csr       in          csr_write           csr_index, csr_wdata
//
// one item per cycle while the queue has room; the back handles one queued item a cycle
// while no held result is stalled; items pass the queue and then the result register
// reset is synchronous and restores the default registers and the hunting state
// rsp_stall holds the result register; the four-entry queue absorbs items until full
module info_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ifr_pkg::req_type              req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ifr_pkg::rsp_type              rsp_item,
   input  logic                          csr_write,
   input  logic [ifr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);
   import ifr_pkg::*;

   cls_type    push_item, pop_item;
   logic       queue_full, queue_push, not_empty, item_pop;
   logic [7:0] escape_mask;
   qin_type    qin_ctl;
   qout_type   qout_ctl;

   assign qin_ctl.push = queue_push;
   assign qout_ctl.pop = item_pop;

   ifr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_item  (push_item),
      .escape_mask (escape_mask)
   );

   ifr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .qin_ctl   (qin_ctl),
      .full      (queue_full),
      .push_item (push_item),
      .qout_ctl  (qout_ctl),
      .not_empty (not_empty),
      .pop_item  (pop_item)
   );

   ifr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (not_empty),
      .item        (pop_item),
      .item_pop    (item_pop),
      .escape_mask (escape_mask),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

@@ hw/rtl/ifr_front.sv @@
// front end: configuration registers, item acceptance and byte classification
module ifr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ifr_pkg::req_type                  req_item,
   input  logic                              csr_write,
   input  logic [ifr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                        csr_wdata,
   input  logic                              queue_full,
   output logic                              queue_push,
   output ifr_pkg::cls_type                  queue_item,
   output logic [7:0]                        escape_mask
);
   import ifr_pkg::*;

   logic [7:0] flag_ff, addr_ff, ctrl0_ff, ctrl1_ff, esc_ff, mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= 8'h7E;
         addr_ff  <= 8'h03;
         ctrl0_ff <= 8'h00;
         ctrl1_ff <= 8'h40;
         esc_ff   <= 8'h7D;
         mask_ff  <= 8'h20;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FLAG:      flag_ff  <= csr_wdata;
            CSR_ADDRESS:   addr_ff  <= csr_wdata;
            CSR_CTRL_ZERO: ctrl0_ff <= csr_wdata;
            CSR_CTRL_ONE:  ctrl1_ff <= csr_wdata;
            CSR_ESCAPE:    esc_ff   <= csr_wdata;
            CSR_MASK:      mask_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = queue_full;
   assign queue_push = req_valid && !queue_full;
   assign escape_mask = mask_ff;

   always_comb begin
      queue_item.clear        = (req_item.operation == OP_CLEAR);
      queue_item.eq_flag      = (req_item.rx_byte == flag_ff);
      queue_item.eq_addr      = (req_item.rx_byte == addr_ff);
      queue_item.eq_ctrl_zero = (req_item.rx_byte == ctrl0_ff);
      queue_item.eq_ctrl_one  = (req_item.rx_byte == ctrl1_ff);
      queue_item.eq_hdr_zero  = (req_item.rx_byte == (addr_ff ^ ctrl0_ff));
      queue_item.eq_hdr_one   = (req_item.rx_byte == (addr_ff ^ ctrl1_ff));
      queue_item.eq_escape    = (req_item.rx_byte == esc_ff);
      queue_item.rx_byte      = req_item.rx_byte;
   end

endmodule

@@ hw/rtl/ifr_queue.sv @@
// short queue of classified items between front and back
module ifr_queue (
   input  logic              clock,
   input  logic              reset,
   input  ifr_pkg::qin_type  qin_ctl,
   output logic              full,
   input  ifr_pkg::cls_type  push_item,
   input  ifr_pkg::qout_type qout_ctl,
   output logic              not_empty,
   output ifr_pkg::cls_type  pop_item
);
   import ifr_pkg::*;

   localparam logic [QPTR_W:0] DEPTH_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

   cls_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full = (count_ff == DEPTH_COUNT);
   assign not_empty = (count_ff != '0);
   assign do_push = qin_ctl.push && !full;
   assign do_pop = qout_ctl.pop && not_empty;
   assign pop_item = entry_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_item;
   end

endmodule

@@ hw/rtl/ifr_back.sv @@
// back end: frame state machine, destuffing, check byte and result register
module ifr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  ifr_pkg::cls_type  item,
   output logic              item_pop,
   input  logic [7:0]        escape_mask,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ifr_pkg::rsp_type  rsp_item
);
   import ifr_pkg::*;

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_FLAG = 3'd1;
   localparam logic [2:0] PH_ADDR = 3'd2;
   localparam logic [2:0] PH_CTRL = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;

   localparam logic [RAW_W:0] RAW_LIMIT = (RAW_W + 1)'(MAX_RAW_BYTES);

   logic [2:0]       phase_ff, phase_in;
   logic             seq_ff, seq_in;
   logic [RAW_W-1:0] raw_ff, raw_in, data_ff, data_in;
   logic [7:0]       held_ff, held_in, xor_ff, xor_in;
   logic             held_valid_ff, held_valid_in, esc_ff, esc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             emit, good, deliver;
   rsp_type          result;
   logic [RAW_W:0]   raw_next;
   logic [7:0]       dbyte;
   logic [31:0]      len_wide, rx_wide;

   assign item_pop = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      phase_in = phase_ff;
      seq_in = seq_ff;
      raw_in = raw_ff;
      data_in = data_ff;
      held_in = held_ff;
      held_valid_in = held_valid_ff;
      esc_in = esc_ff;
      xor_in = xor_ff;
      emit = 1'b0;
      result = '0;
      deliver = 1'b0;
      dbyte = item.rx_byte;
      good = held_valid_ff && !esc_ff && (held_ff == xor_ff);
      raw_next = {1'b0, raw_ff} + 1'b1;
      len_wide = 32'(data_ff);
      rx_wide = 32'(raw_ff) + 32'(HEADER_BYTES);
      if (item.clear) begin
         phase_in = PH_HUNT;
         seq_in = 1'b0;
         raw_in = '0;
         data_in = '0;
         held_in = '0;
         held_valid_in = 1'b0;
         esc_in = 1'b0;
         xor_in = '0;
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (item.eq_flag) phase_in = PH_FLAG;
            end
            PH_FLAG: begin
               if (item.eq_addr) phase_in = PH_ADDR;
               else if (!item.eq_flag) phase_in = PH_HUNT;
            end
            PH_ADDR: begin
               if (item.eq_ctrl_zero) begin
                  seq_in = 1'b0;
                  phase_in = PH_CTRL;
               end else if (item.eq_ctrl_one) begin
                  seq_in = 1'b1;
                  phase_in = PH_CTRL;
               end else if (item.eq_flag) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CTRL: begin
               if (seq_ff ? item.eq_hdr_one : item.eq_hdr_zero) begin
                  phase_in = PH_DATA;
                  raw_in = '0;
                  data_in = '0;
                  held_in = '0;
                  held_valid_in = 1'b0;
                  esc_in = 1'b0;
                  xor_in = '0;
               end else if (item.eq_flag) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (item.eq_flag) begin
                  emit = 1'b1;
                  result.result_kind = KIND_END;
                  result.frame_good = good;
                  result.sequence_number = seq_ff;
                  result.payload_length = len_wide[LEN_W-1:0];
                  result.received_bytes = good ? rx_wide[LEN_W-1:0] : '0;
                  phase_in = PH_DONE;
               end else if (raw_next >= RAW_LIMIT) begin
                  emit = 1'b1;
                  result.result_kind = KIND_ABORT;
                  result.sequence_number = seq_ff;
                  phase_in = PH_HUNT;
                  seq_in = 1'b0;
                  raw_in = '0;
                  data_in = '0;
                  held_in = '0;
                  held_valid_in = 1'b0;
                  esc_in = 1'b0;
                  xor_in = '0;
               end else begin
                  raw_in = raw_next[RAW_W-1:0];
                  if (esc_ff) begin
                     dbyte = item.rx_byte ^ escape_mask;
                     esc_in = 1'b0;
                     deliver = 1'b1;
                  end else if (item.eq_escape) begin
                     esc_in = 1'b1;
                  end else begin
                     deliver = 1'b1;
                  end
                  if (deliver) begin
                     if (held_valid_ff) begin
                        emit = 1'b1;
                        result.result_kind = KIND_DATA;
                        result.payload_byte = held_ff;
                        xor_in = xor_ff ^ held_ff;
                        data_in = data_ff + 1'b1;
                     end
                     held_in = dbyte;
                     held_valid_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (item_pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         seq_ff <= 1'b0;
         raw_ff <= '0;
         data_ff <= '0;
         held_ff <= '0;
         held_valid_ff <= 1'b0;
         esc_ff <= 1'b0;
         xor_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff <= phase_in;
            seq_ff <= seq_in;
            raw_ff <= raw_in;
            data_ff <= data_in;
            held_ff <= held_in;
            held_valid_ff <= held_valid_in;
            esc_ff <= esc_in;
            xor_ff <= xor_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

@@ tb/tb_info_frame_receiver.sv @@
// testbench of the information frame receiver: framed byte traffic, stall pressure, result checks
module tb_info_frame_receiver;
   import ifr_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_OFF_CYCLES = 48;
   localparam int HOLD_OFF_AFTER = 300;
   localparam int MAX_PRINTS = 200;

   typedef enum logic [2:0] {
      RX_HUNT, RX_FLAG, RX_ADDR, RX_CTRL, RX_DATA, RX_DONE
   } rx_phase_e;

   typedef enum logic [1:0] {
      FR_GOOD, FR_BAD_BCC, FR_EMPTY, FR_DANGLING
   } frame_mode_e;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_item;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FLAG;
   logic [7:0]           csr_wdata = '0;

   // register copies, reset values
   logic [7:0] rx_flag = 8'h7E;
   logic [7:0] rx_addr = 8'h03;
   logic [7:0] rx_ctrl0 = 8'h00;
   logic [7:0] rx_ctrl1 = 8'h40;
   logic [7:0] rx_esc = 8'h7D;
   logic [7:0] rx_mask = 8'h20;

   // deframer state
   rx_phase_e  ph = RX_HUNT;
   logic       fr_seq = 1'b0;
   int         fr_raw = 0;
   int         fr_len = 0;
   logic [7:0] fr_held = '0;
   logic       fr_held_ok = 1'b0;
   logic       fr_esc = 1'b0;
   logic [7:0] fr_xor = '0;

   req_type    line_items[$];
   rsp_type    frame_results_due[$];
   logic [7:0] frame_data[$];
   rsp_type    due;

   int   n_taken = 0;
   int   n_errors = 0;
   int   n_prints = 0;
   int   quiet_cycles = 0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   logic calm = 1'b0;
   logic req_fired = 1'b0;

   info_frame_receiver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic clear_frame_state();
      ph = RX_HUNT;
      fr_seq = 1'b0;
      fr_raw = 0;
      fr_len = 0;
      fr_held = '0;
      fr_held_ok = 1'b0;
      fr_esc = 1'b0;
      fr_xor = '0;
   endtask

   task automatic deframe_byte(input req_type it);
      rsp_type    r;
      logic [7:0] b;
      logic [7:0] d;
      logic [7:0] hdr;
      logic       deliver;
      logic       good;
      logic       keep_seq;
      r = '0;
      b = it.rx_byte;
      d = '0;
      deliver = 1'b0;
      if (it.operation == OP_CLEAR) begin
         clear_frame_state();
         return;
      end
      case (ph)
         RX_HUNT: begin
            if (b == rx_flag) ph = RX_FLAG;
         end
         RX_FLAG: begin
            if (b == rx_addr) ph = RX_ADDR;
            else if (b != rx_flag) ph = RX_HUNT;
         end
         RX_ADDR: begin
            if (b == rx_ctrl0) begin
               fr_seq = 1'b0;
               ph = RX_CTRL;
            end else if (b == rx_ctrl1) begin
               fr_seq = 1'b1;
               ph = RX_CTRL;
            end else if (b == rx_flag) begin
               ph = RX_FLAG;
            end else begin
               ph = RX_HUNT;
            end
         end
         RX_CTRL: begin
            hdr = rx_addr ^ (fr_seq ? rx_ctrl1 : rx_ctrl0);
            if (b == hdr) begin
               keep_seq = fr_seq;
               clear_frame_state();
               fr_seq = keep_seq;
               ph = RX_DATA;
            end else if (b == rx_flag) begin
               ph = RX_FLAG;
            end else begin
               ph = RX_HUNT;
            end
         end
         RX_DATA: begin
            if (b == rx_flag) begin
               good = fr_held_ok && !fr_esc && (fr_held == fr_xor);
               r.result_kind = KIND_END;
               r.frame_good = good;
               r.sequence_number = fr_seq;
               r.payload_length = LEN_W'(fr_len);
               r.received_bytes = good ? LEN_W'(fr_raw + HEADER_BYTES) : '0;
               frame_results_due.push_back(r);
               ph = RX_DONE;
            end else begin
               fr_raw++;
               if (fr_raw >= MAX_RAW_BYTES) begin
                  keep_seq = fr_seq;
                  clear_frame_state();
                  r.result_kind = KIND_ABORT;
                  r.sequence_number = keep_seq;
                  frame_results_due.push_back(r);
               end else begin
                  if (fr_esc) begin
                     d = b ^ rx_mask;
                     fr_esc = 1'b0;
                     deliver = 1'b1;
                  end else if (b == rx_esc) begin
                     fr_esc = 1'b1;
                  end else begin
                     d = b;
                     deliver = 1'b1;
                  end
                  if (deliver) begin
                     if (fr_held_ok) begin
                        r.result_kind = KIND_DATA;
                        r.payload_byte = fr_held;
                        frame_results_due.push_back(r);
                        fr_xor ^= fr_held;
                        fr_len++;
                     end
                     fr_held = d;
                     fr_held_ok = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b);
      line_items.push_back('{OP_RECEIVE, b});
   endtask

   task automatic push_clear();
      line_items.push_back('{OP_CLEAR, 8'($urandom)});
   endtask

   task automatic push_stuffed(input logic [7:0] d);
      if (d == rx_flag || d == rx_esc) begin
         push_byte(rx_esc);
         push_byte(d ^ rx_mask);
      end else begin
         push_byte(d);
      end
   endtask

   task automatic push_frame(input logic s, input frame_mode_e mode);
      logic [7:0] c;
      logic [7:0] bcc;
      c = s ? rx_ctrl1 : rx_ctrl0;
      bcc = '0;
      push_byte(rx_flag);
      push_byte(rx_addr);
      push_byte(c);
      push_byte(rx_addr ^ c);
      if (mode != FR_EMPTY) begin
         foreach (frame_data[i]) begin
            push_stuffed(frame_data[i]);
            bcc ^= frame_data[i];
         end
         if (mode == FR_BAD_BCC) bcc ^= 8'($urandom_range(1, 255));
         push_stuffed(bcc);
         if (mode == FR_DANGLING) push_byte(rx_esc);
      end
      push_byte(rx_flag);
   endtask

   // runs the raw count up to the limit, then keeps hunting without a flag
   task automatic push_long_frame();
      logic [7:0] b;
      push_byte(rx_flag);
      push_byte(rx_addr);
      push_byte(rx_ctrl1);
      push_byte(rx_addr ^ rx_ctrl1);
      repeat (MAX_RAW_BYTES + 6) begin
         b = 8'($urandom);
         if (b == rx_flag) b = ~b;
         push_byte(b);
      end
      push_clear();
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0: return rx_flag;
         1: return rx_addr;
         2: return rx_ctrl0;
         3: return rx_ctrl1;
         4: return rx_esc;
         5: return rx_addr ^ rx_ctrl0;
         6: return rx_addr ^ rx_ctrl1;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_traffic(input int count);
      int   target;
      int   sel;
      int   len;
      int   k;
      logic s;
      target = line_items.size() + count;
      while (line_items.size() < target) begin
         sel = $urandom_range(0, 99);
         s = 1'($urandom);
         if (sel < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            frame_data.delete();
            repeat (len) frame_data.push_back(pick_byte());
            if ($urandom_range(0, 3) == 0) push_byte(rx_flag);
            if (sel < 45) push_frame(s, FR_GOOD);
            else push_frame(s, frame_mode_e'($urandom_range(1, 3)));
            repeat ($urandom_range(0, 2)) push_byte(pick_byte());
            push_clear();
         end else if (sel < 88) begin
            // header cut short or followed by junk
            k = $urandom_range(1, 4);
            push_byte(rx_flag);
            if (k > 1) push_byte(rx_addr);
            if (k > 2) push_byte(s ? rx_ctrl1 : rx_ctrl0);
            if (k > 3) push_byte(rx_addr ^ (s ? rx_ctrl1 : rx_ctrl0));
            repeat ($urandom_range(1, 4)) push_byte(pick_byte());
            if ($urandom_range(0, 3) != 0) push_clear();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 5) == 0) push_clear();
               else push_byte(pick_byte());
            end
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_FLAG: rx_flag = v;
         CSR_ADDRESS: rx_addr = v;
         CSR_CTRL_ZERO: rx_ctrl0 = v;
         CSR_CTRL_ONE: rx_ctrl1 = v;
         CSR_ESCAPE: rx_esc = v;
         CSR_MASK: rx_mask = v;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] f, input logic [7:0] a,
                                 input logic [7:0] c0, input logic [7:0] c1,
                                 input logic [7:0] e, input logic [7:0] m);
      write_reg(CSR_FLAG, f);
      write_reg(CSR_ADDRESS, a);
      write_reg(CSR_CTRL_ZERO, c0);
      write_reg(CSR_CTRL_ONE, c1);
      write_reg(CSR_ESCAPE, e);
      write_reg(CSR_MASK, m);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic settle();
      while (line_items.size() != 0 || frame_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // escaped flag and top byte in a good frame, then a byte ignored after the end
      frame_data = {8'h7E, 8'hFF};
      push_frame(1'b0, FR_GOOD);
      push_byte(8'h55);
      push_clear();
      // repeated flag, flag in place of the control byte, escape followed by escape
      push_byte(rx_flag);
      push_byte(rx_flag);
      push_byte(rx_addr);
      push_byte(rx_flag);
      push_byte(rx_addr);
      push_byte(rx_ctrl1);
      push_byte(rx_addr ^ rx_ctrl1);
      push_byte(rx_esc);
      push_byte(rx_esc);
      push_byte(8'h11);
      push_byte((rx_esc ^ rx_mask) ^ 8'h11);
      push_byte(rx_flag);
      push_clear();
      // wrong control, flag at header check, wrong header check
      push_byte(rx_flag);
      push_byte(rx_addr);
      push_byte(8'h22);
      push_byte(rx_flag);
      push_byte(rx_addr);
      push_byte(rx_ctrl0);
      push_byte(rx_flag);
      push_byte(rx_addr);
      push_byte(rx_ctrl0);
      push_byte(8'h99);
      push_frame(1'b1, FR_EMPTY);
      push_clear();
      frame_data = {8'h00};
      push_frame(1'b0, FR_DANGLING);
      push_clear();
      add_traffic(150);
      settle();

      apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      add_traffic(130);
      settle();

      apply_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF);
      add_traffic(130);
      settle();

      // address equal to flag, both control bytes equal, zero mask
      apply_settings(8'hA5, 8'hA5, 8'h3C, 8'h3C, 8'h5A, 8'h00);
      add_traffic(130);
      settle();

      apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      push_long_frame();
      add_traffic(40);
      settle();

      calm = 1'b1;
      apply_settings(8'h7E, 8'h03, 8'h00, 8'h40, 8'h7D, 8'h20);
      add_traffic(150);
      settle();

      if (n_errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // item driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_fired)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (line_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_item <= line_items[0];
         end
      end
   end

   // result stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_taken >= HOLD_OFF_AFTER && rsp_valid) begin
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_results_due.size() == 0) begin
               n_errors++;
               if (n_prints < MAX_PRINTS) begin
                  n_prints++;
                  $display("%0t unexpected result: kind %0d byte %h good %b seq %b len %0d rx %0d",
                           $time, rsp_item.result_kind, rsp_item.payload_byte,
                           rsp_item.frame_good, rsp_item.sequence_number,
                           rsp_item.payload_length, rsp_item.received_bytes);
               end
            end else begin
               due = frame_results_due.pop_front();
               if (rsp_item !== due) begin
                  n_errors++;
                  if (n_prints < MAX_PRINTS) begin
                     n_prints++;
                     $display({"%0t mismatch: expected kind %0d byte %h good %b seq %b len %0d",
                               " rx %0d, actual kind %0d byte %h good %b seq %b len %0d rx %0d"},
                              $time, due.result_kind, due.payload_byte, due.frame_good,
                              due.sequence_number, due.payload_length, due.received_bytes,
                              rsp_item.result_kind, rsp_item.payload_byte,
                              rsp_item.frame_good, rsp_item.sequence_number,
                              rsp_item.payload_length, rsp_item.received_bytes);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_fired = 1'b1;
            deframe_byte(req_item);
            void'(line_items.pop_front());
            n_taken++;
         end
         if (req_fired || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
